// File: rtl/cetm_pkg.sv
// Package for the cron entry time match block.
// Holds code byte markers, config register indexes, scan phase and shared structs.
// No dependencies.
package cetm_pkg;

    localparam int CODE_W      = 7;
    localparam int IDX_OUT_W   = 16;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 6;
    localparam int FIELD_CNT   = 5;

    localparam logic [CODE_W-1:0] CODE_EXACT = 7'd123;
    localparam logic [CODE_W-1:0] CODE_ANY   = 7'd124;
    localparam logic [CODE_W-1:0] CODE_LIST  = 7'd125;
    localparam logic [CODE_W-1:0] CODE_RANGE = 7'd126;
    localparam logic [CODE_W-1:0] CODE_END   = 7'd127;
    localparam logic [CODE_W-1:0] CODE_TERM  = 7'd0;

    localparam logic [CFG_IDX_W-1:0] REG_MINUTE  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HOUR    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DAY     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MONTH   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_WEEKDAY = 3'd4;

    localparam logic [2:0] FLD_MINUTE  = 3'd0;
    localparam logic [2:0] FLD_HOUR    = 3'd1;
    localparam logic [2:0] FLD_DAY     = 3'd2;
    localparam logic [2:0] FLD_MONTH   = 3'd3;
    localparam logic [2:0] FLD_WEEKDAY = 3'd4;
    localparam logic [2:0] FLD_LAST    = 3'd5;

    typedef enum logic [2:0] {
        PH_CODE       = 3'd0,
        PH_EXACT      = 3'd1,
        PH_LIST_SEEK  = 3'd2,
        PH_LIST_FOUND = 3'd3,
        PH_RANGE_LO   = 3'd4,
        PH_RANGE_HI   = 3'd5,
        PH_COMMAND    = 3'd6
    } cetm_phase_t;

    typedef struct packed {
        logic [5:0] minute;
        logic [4:0] hour;
        logic [4:0] day;
        logic [3:0] month;
        logic [2:0] weekday;
    } cetm_time_t;

    typedef struct packed {
        logic                 valid;
        logic [IDX_OUT_W-1:0] index;
        logic                 matched;
        logic                 end_of_table;
    } cetm_result_t;

endpackage

// File: rtl/cetm_cfg_regs.sv
// Current-time configuration registers for the cron entry time match block.
// Depends on cetm_pkg.
module cetm_cfg_regs
    import cetm_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    output cetm_time_t            time_now
);

    cetm_time_t time_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            time_reg.minute  <= 6'd0;
            time_reg.hour    <= 5'd0;
            time_reg.day     <= 5'd1;
            time_reg.month   <= 4'd1;
            time_reg.weekday <= 3'd0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_MINUTE:  time_reg.minute  <= cfg_wdata;
                REG_HOUR:    time_reg.hour    <= cfg_wdata[4:0];
                REG_DAY:     time_reg.day     <= cfg_wdata[4:0];
                REG_MONTH:   time_reg.month   <= cfg_wdata[3:0];
                REG_WEEKDAY: time_reg.weekday <= cfg_wdata[2:0];
                default:     ; // unknown index ignored
            endcase
        end
    end

    assign time_now = time_reg;

endmodule

// File: rtl/cetm_scan.sv
// Table scan state and field matching for the cron entry time match block.
// One code byte per step; result is combinational, registered by the caller.
// Depends on cetm_pkg.
module cetm_scan
    import cetm_pkg::*;
#(
    parameter int ENTRY_INDEX_BITS = 16
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  logic [CODE_W-1:0] code_byte,
    input  cetm_time_t        time_now,
    output cetm_result_t      result
);

    logic [2:0]                  field_reg,   field_next;
    cetm_phase_t                 phase_reg,   phase_next;
    logic [CODE_W-1:0]           lo_reg,      lo_next;
    logic                        miss_reg,    miss_next;
    logic [ENTRY_INDEX_BITS-1:0] cnt_reg,     cnt_next;

    logic [CODE_W-1:0]    now;
    logic [IDX_OUT_W-1:0] idx_out;
    logic [2:0]           field_inc;
    cetm_phase_t          phase_done;
    logic                 range_hit;

    always_comb
    begin
        unique case (field_reg)
            FLD_MINUTE:  now = {1'b0, time_now.minute};
            FLD_HOUR:    now = {2'b0, time_now.hour};
            FLD_DAY:     now = {2'b0, time_now.day};
            FLD_MONTH:   now = {3'b0, time_now.month};
            FLD_WEEKDAY: now = {4'b0, time_now.weekday};
            default:     now = '0;
        endcase
    end

    generate
        if (ENTRY_INDEX_BITS >= IDX_OUT_W)
        begin : g_idx_trunc
            assign idx_out = cnt_reg[IDX_OUT_W-1:0];
        end
        else
        begin : g_idx_ext
            assign idx_out = {{(IDX_OUT_W-ENTRY_INDEX_BITS){1'b0}}, cnt_reg};
        end
    endgenerate

    assign field_inc  = field_reg + 3'd1;
    assign phase_done = (field_inc >= FLD_LAST) ? PH_COMMAND : PH_CODE;

    // low below high: inclusive; otherwise wraparound
    assign range_hit = (lo_reg < code_byte) ? ((lo_reg <= now) && (now <= code_byte))
                                            : ((now >= lo_reg) || (now <= code_byte));

    always_comb
    begin
        field_next = field_reg;
        phase_next = phase_reg;
        lo_next    = lo_reg;
        miss_next  = miss_reg;
        cnt_next   = cnt_reg;
        result     = '0;

        unique case (phase_reg)
            PH_CODE:
            begin
                if ((field_reg == FLD_MINUTE) && (code_byte == CODE_END))
                begin
                    result.valid        = 1'b1;
                    result.index        = idx_out;
                    result.end_of_table = 1'b1;
                    field_next = FLD_MINUTE;
                    phase_next = PH_CODE;
                    lo_next    = '0;
                    miss_next  = 1'b0;
                    cnt_next   = '0;
                end
                else if (code_byte == CODE_EXACT)
                    phase_next = PH_EXACT;
                else if (code_byte == CODE_ANY)
                begin
                    field_next = field_inc;
                    phase_next = phase_done;
                end
                else if (code_byte == CODE_LIST)
                    phase_next = PH_LIST_SEEK;
                else if (code_byte == CODE_RANGE)
                    phase_next = PH_RANGE_LO;
                else
                begin
                    // bare byte, compared directly
                    if (code_byte != now)
                        miss_next = 1'b1;
                    field_next = field_inc;
                    phase_next = phase_done;
                end
            end
            PH_EXACT:
            begin
                if (code_byte != now)
                    miss_next = 1'b1;
                field_next = field_inc;
                phase_next = phase_done;
            end
            PH_LIST_SEEK:
            begin
                if (code_byte == CODE_LIST)
                begin
                    miss_next  = 1'b1;
                    field_next = field_inc;
                    phase_next = phase_done;
                end
                else if (code_byte == now)
                    phase_next = PH_LIST_FOUND;
            end
            PH_LIST_FOUND:
            begin
                if (code_byte == CODE_LIST)
                begin
                    field_next = field_inc;
                    phase_next = phase_done;
                end
            end
            PH_RANGE_LO:
            begin
                lo_next    = code_byte;
                phase_next = PH_RANGE_HI;
            end
            PH_RANGE_HI:
            begin
                if (!range_hit)
                    miss_next = 1'b1;
                field_next = field_inc;
                phase_next = phase_done;
            end
            PH_COMMAND:
            begin
                if (code_byte == CODE_TERM)
                begin
                    result.valid   = 1'b1;
                    result.index   = idx_out;
                    result.matched = !miss_reg;
                    if (cnt_reg != {ENTRY_INDEX_BITS{1'b1}})
                        cnt_next = cnt_reg + ENTRY_INDEX_BITS'(1);
                    field_next = FLD_MINUTE;
                    phase_next = PH_CODE;
                    lo_next    = '0;
                    miss_next  = 1'b0;
                end
            end
            default:
            begin
                field_next = FLD_MINUTE;
                phase_next = PH_CODE;
                lo_next    = '0;
                miss_next  = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            field_reg <= FLD_MINUTE;
            phase_reg <= PH_CODE;
            lo_reg    <= '0;
            miss_reg  <= 1'b0;
            cnt_reg   <= '0;
        end
        else if (step)
        begin
            field_reg <= field_next;
            phase_reg <= phase_next;
            lo_reg    <= lo_next;
            miss_reg  <= miss_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

// File: rtl/cron_entry_time_match_core.sv
// Top level of the cron entry time match block: input register, scan logic,
// result register. Depends on cetm_pkg, cetm_cfg_regs and cetm_scan.
//
// Usage:
//   s_* stream carries the compiled schedule table, one code byte per item.
//   m_* stream returns one item per finished entry (index, match flag) and one
//   end-of-table item (tuser high) when the end marker starts an entry.
//   cfg_* writes the current minute, hour, day, month and weekday; write only
//   while the stream is idle.
// Path: a byte is accepted into the input register; the result it causes is
//   captured in the result register, which drives m_tvalid.
// Throughput: one byte per cycle unless a result waits with m_tready low; the
//   scan state steps once per byte, by the phase and compare logic between registers.
// Reset: asynchronous, active low; scan state and entry count cleared, time
//   registers set to minute 0, hour 0, day 1, month 1, weekday 0.
// Stall: while a result waits with m_tready low, the byte held in the input
//   register waits too and s_tready drops once that register is full.
module cron_entry_time_match_core
    import cetm_pkg::*;
#(
    parameter int ENTRY_INDEX_BITS = 16
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [7:0]            s_tdata,   // [6:0] code_byte, [7] zero
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [23:0]           m_tdata,   // [15:0] entry_index, [16] entry_matched
    output logic                  m_tuser,   // [0] end_of_table
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    logic              in_valid_reg;
    logic [CODE_W-1:0] in_byte_reg;
    logic              step;
    logic              accept;

    cetm_time_t   time_now;
    cetm_result_t res;

    logic                 out_valid_reg;
    logic [IDX_OUT_W-1:0] out_index_reg;
    logic                 out_matched_reg;
    logic                 out_eot_reg;

    assign step     = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || step;
    assign accept   = s_tvalid && s_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (accept)
            in_valid_reg <= 1'b1;
        else if (step)
            in_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            in_byte_reg <= s_tdata[CODE_W-1:0];
    end

    cetm_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .time_now  (time_now)
    );

    cetm_scan #(
        .ENTRY_INDEX_BITS (ENTRY_INDEX_BITS)
    ) u_scan (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .code_byte (in_byte_reg),
        .time_now  (time_now),
        .result    (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (step && res.valid)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (step && res.valid)
        begin
            out_index_reg   <= res.index;
            out_matched_reg <= res.matched;
            out_eot_reg     <= res.end_of_table;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0, out_matched_reg, out_index_reg};
    assign m_tuser  = out_eot_reg;

endmodule

// File: rtl/cetm_checker.sv
// Port-level checks for cron_entry_time_match_core, attached by bind.
// Depends on cetm_pkg.
module cetm_checker
    import cetm_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata,
    input logic        m_tuser
);

    // no result survives reset
    a_reset_idle: assert property (@(posedge clk) !rst_n |-> !m_tvalid)
        else $error("m_tvalid high during reset");

    // end-of-table item never reports a match
    a_eot_nomatch: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser) |-> !m_tdata[16])
        else $error("end-of-table item with match flag set");

    a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[23:17] == 7'd0))
        else $error("m_tdata padding not zero");

    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> m_tvalid)
        else $error("m_tvalid dropped while stalled");

    a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> ($stable(m_tdata) && $stable(m_tuser)))
        else $error("result changed while stalled");

endmodule

bind cron_entry_time_match_core cetm_checker u_cetm_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

// File: dv/cetm_match_checker.sv
`timescale 1ns / 1ps
// Checker for cron_entry_time_match_core: watches the byte, result and config
// channels, predicts each entry result and compares it field by field.
// Depends on cetm_pkg.
module cetm_match_checker
    import cetm_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [7:0]            s_tdata,
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [23:0]           m_tdata,
    input  logic                  m_tuser,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    output int                    fail_count,
    output int                    outstanding
);

    typedef struct packed {
        logic [IDX_OUT_W-1:0] index;
        logic                 matched;
        logic                 end_of_table;
    } entry_result_t;

    cetm_time_t           now_time;
    logic [2:0]           field_no;
    cetm_phase_t          phase;
    logic [CODE_W-1:0]    range_lo;
    logic                 miss_seen;
    logic [IDX_OUT_W-1:0] entry_count;
    entry_result_t        expected_results [$];
    int                   mismatches;

    function automatic logic [CODE_W-1:0] field_time();
        case (field_no)
            FLD_MINUTE:  return {1'b0, now_time.minute};
            FLD_HOUR:    return {2'b0, now_time.hour};
            FLD_DAY:     return {2'b0, now_time.day};
            FLD_MONTH:   return {3'b0, now_time.month};
            FLD_WEEKDAY: return {4'b0, now_time.weekday};
            default:     return '0;
        endcase
    endfunction

    task automatic close_field();
        field_no = field_no + 3'd1;
        phase = (field_no >= FLD_LAST) ? PH_COMMAND : PH_CODE;
    endtask

    task automatic restart_entry();
        field_no  = FLD_MINUTE;
        phase     = PH_CODE;
        range_lo  = '0;
        miss_seen = 1'b0;
    endtask

    task automatic note_failure(input string what);
        if (mismatches < 10)
            $display("[%0t] mismatch: %s", $realtime, what);
        mismatches++;
    endtask

    // One table byte through the scan state; pushes the result it causes, if any.
    task automatic scan_byte(input logic [CODE_W-1:0] b);
        logic [CODE_W-1:0] now;
        entry_result_t     res;
        now = field_time();
        case (phase)
            PH_CODE:
            begin
                if (field_no == FLD_MINUTE && b == CODE_END)
                begin
                    res.index        = entry_count;
                    res.matched      = 1'b0;
                    res.end_of_table = 1'b1;
                    expected_results.push_back(res);
                    restart_entry();
                    entry_count = '0;
                end
                else if (b == CODE_EXACT)
                    phase = PH_EXACT;
                else if (b == CODE_ANY)
                    close_field();
                else if (b == CODE_LIST)
                    phase = PH_LIST_SEEK;
                else if (b == CODE_RANGE)
                    phase = PH_RANGE_LO;
                else
                begin
                    // bare byte, the end marker past the first field included
                    if (b != now)
                        miss_seen = 1'b1;
                    close_field();
                end
            end
            PH_EXACT:
            begin
                if (b != now)
                    miss_seen = 1'b1;
                close_field();
            end
            PH_LIST_SEEK:
            begin
                if (b == CODE_LIST)
                begin
                    miss_seen = 1'b1;
                    close_field();
                end
                else if (b == now)
                    phase = PH_LIST_FOUND;
            end
            PH_LIST_FOUND:
            begin
                if (b == CODE_LIST)
                    close_field();
            end
            PH_RANGE_LO:
            begin
                range_lo = b;
                phase    = PH_RANGE_HI;
            end
            PH_RANGE_HI:
            begin
                if (range_lo < b)
                begin
                    if (!(range_lo <= now && now <= b))
                        miss_seen = 1'b1;
                end
                else if (!(now >= range_lo || now <= b))
                    miss_seen = 1'b1;   // wrapping range
                close_field();
            end
            PH_COMMAND:
            begin
                if (b == CODE_TERM)
                begin
                    res.index        = entry_count;
                    res.matched      = !miss_seen;
                    res.end_of_table = 1'b0;
                    expected_results.push_back(res);
                    if (entry_count != '1)
                        entry_count = entry_count + 1'b1;
                    restart_entry();
                end
            end
            default:
                restart_entry();
        endcase
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        entry_result_t want;
        if (!rst_n)
        begin
            now_time.minute  = 6'd0;
            now_time.hour    = 5'd0;
            now_time.day     = 5'd1;
            now_time.month   = 4'd1;
            now_time.weekday = 3'd0;
            restart_entry();
            entry_count = '0;
            expected_results.delete();
            mismatches = 0;
            fail_count  <= 0;
            outstanding <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_MINUTE:  now_time.minute  = cfg_wdata[5:0];
                    REG_HOUR:    now_time.hour    = cfg_wdata[4:0];
                    REG_DAY:     now_time.day     = cfg_wdata[4:0];
                    REG_MONTH:   now_time.month   = cfg_wdata[3:0];
                    REG_WEEKDAY: now_time.weekday = cfg_wdata[2:0];
                    default:     ;
                endcase
            end
            if (s_tvalid && s_tready)
                scan_byte(s_tdata[CODE_W-1:0]);
            if (m_tvalid && m_tready)
            begin
                if (expected_results.size() == 0)
                    note_failure($sformatf("result idx=%0d match=%0b eot=%0b with none expected",
                                           m_tdata[15:0], m_tdata[16], m_tuser));
                else
                begin
                    want = expected_results.pop_front();
                    if (m_tdata[15:0] !== want.index || m_tdata[16] !== want.matched
                        || m_tuser !== want.end_of_table)
                        note_failure($sformatf(
                            "expected idx=%0d match=%0b eot=%0b, got idx=%0d match=%0b eot=%0b",
                            want.index, want.matched, want.end_of_table,
                            m_tdata[15:0], m_tdata[16], m_tuser));
                end
            end
            fail_count  <= mismatches;
            outstanding <= expected_results.size();
        end
    end

endmodule

// File: dv/tb_cron_entry_time_match_core.sv
`timescale 1ns / 1ps
// Testbench top for cron_entry_time_match_core: clock, reset, schedule table
// stimulus, config writes and verdict. Depends on cetm_pkg and cetm_match_checker.
module tb_cron_entry_time_match_core;
    import cetm_pkg::*;

    localparam int CYCLE_LIMIT   = 200000;
    localparam int SETTLE_CYCLES = 6;
    localparam int PHASE_ITEMS   = 65;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

    logic                  clk;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [7:0]            s_tdata;    // [6:0] code_byte, [7] zero
    logic                  m_tvalid;
    logic                  m_tready;
    logic [23:0]           m_tdata;    // [15:0] entry_index, [16] entry_matched
    logic                  m_tuser;    // [0] end_of_table
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    int         fail_count;
    int         outstanding;
    int         tx_idle;
    int         rx_idle;
    int         codes_sent;
    int         cycle_count;
    cetm_time_t clock_now;

    cron_entry_time_match_core u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    cetm_match_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    always @(posedge clk)
    begin
        m_tready <= ($urandom_range(99) >= rx_idle);
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    task automatic send_code(input logic [CODE_W-1:0] b);
        while ($urandom_range(99) < tx_idle)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {1'b0, b};
        do
            @(posedge clk);
        while (!s_tready);
        codes_sent++;
    endtask

    // Sender holds off until every result is back, then lets the pipe settle.
    task automatic drain();
        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (outstanding != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val[CFG_DATA_W-1:0];
        @(posedge clk);
    endtask

    task automatic set_time(input int mi, input int hr, input int dy, input int mo,
                            input int wd);
        clock_now.minute  = mi[5:0];
        clock_now.hour    = hr[4:0];
        clock_now.day     = dy[4:0];
        clock_now.month   = mo[3:0];
        clock_now.weekday = wd[2:0];
        write_reg(REG_UNUSED, 63);
        write_reg(REG_MINUTE, mi);
        write_reg(REG_HOUR, hr);
        write_reg(REG_DAY, dy);
        write_reg(REG_MONTH, mo);
        write_reg(REG_WEEKDAY, wd);
        cfg_we <= 1'b0;
    endtask

    function automatic logic [CODE_W-1:0] time_of(input int f);
        case (f)
            FLD_MINUTE:  return {1'b0, clock_now.minute};
            FLD_HOUR:    return {2'b0, clock_now.hour};
            FLD_DAY:     return {2'b0, clock_now.day};
            FLD_MONTH:   return {3'b0, clock_now.month};
            default:     return {4'b0, clock_now.weekday};
        endcase
    endfunction

    // Half the values hit the current time so that whole entries match often.
    function automatic logic [CODE_W-1:0] pick_value(input logic [CODE_W-1:0] now);
        if ($urandom_range(1) == 0)
            return now;
        return CODE_W'($urandom_range(127));
    endfunction

    function automatic logic [CODE_W-1:0] pick_bound();
        if ($urandom_range(3) == 0)
            return CODE_W'($urandom_range(127));
        return CODE_W'($urandom_range(63));
    endfunction

    task automatic send_entry();
        logic [CODE_W-1:0] now;
        logic [CODE_W-1:0] v;
        int                n;
        for (int f = 0; f < FIELD_CNT; f++)
        begin
            now = time_of(f);
            case ($urandom_range(4))
                0:
                    send_code(CODE_ANY);
                1:
                begin
                    send_code(CODE_EXACT);
                    send_code(pick_value(now));
                end
                2:
                begin
                    send_code(CODE_LIST);
                    n = $urandom_range(3);
                    repeat (n)
                    begin
                        v = pick_value(now);
                        send_code((v == CODE_LIST) ? now : v);
                    end
                    send_code(CODE_LIST);
                end
                3:
                begin
                    send_code(CODE_RANGE);
                    send_code(pick_bound());
                    send_code(pick_bound());
                end
                default:
                begin
                    v = pick_value(now);
                    send_code((v >= CODE_EXACT) ? now : v);
                end
            endcase
        end
        n = $urandom_range(3);
        repeat (n) send_code(CODE_W'($urandom_range(1, 127)));
        send_code(CODE_TERM);
    endtask

    task automatic run_tables(input int count);
        int start;
        int pick;
        int n;
        start = codes_sent;
        while (codes_sent - start < count)
        begin
            pick = $urandom_range(99);
            if (pick < 8)
                send_code(CODE_END);
            else if (pick < 18)
            begin
                // loose bytes that break entry framing
                n = $urandom_range(1, 4);
                repeat (n) send_code(CODE_W'($urandom_range(127)));
            end
            else
                send_entry();
        end
        drain();
    endtask

    initial
    begin
        logic [CODE_W-1:0] warmup [$];
        rst_n       = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        m_tready    = 1'b0;
        cfg_we      = 1'b0;
        cfg_index   = '0;
        cfg_wdata   = '0;
        cycle_count = 0;
        codes_sent  = 0;
        tx_idle     = 38;
        rx_idle     = 55;
        clock_now   = {6'd0, 5'd0, 5'd1, 4'd1, 3'd0};
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // end of an empty table, a matching entry of exact, list, range and bare fields
        // (markers as data, wrapping ranges), a failing entry, end of table
        warmup = '{CODE_END,
                   CODE_EXACT, 7'd0,
                   CODE_LIST, CODE_END, 7'd0, CODE_LIST,
                   CODE_RANGE, CODE_END, 7'd1,
                   7'd1,
                   CODE_RANGE, 7'd6, 7'd0,
                   CODE_TERM,
                   CODE_LIST, CODE_LIST,
                   CODE_END,
                   CODE_ANY, CODE_ANY, CODE_ANY,
                   CODE_TERM,
                   CODE_END};
        foreach (warmup[i])
            send_code(warmup[i]);
        drain();

        set_time(59, 23, 31, 12, 6);
        run_tables(PHASE_ITEMS);
        set_time(63, 31, 0, 15, 7);
        run_tables(PHASE_ITEMS);

        tx_idle = 55;
        rx_idle = 38;
        set_time($urandom_range(59), $urandom_range(23), $urandom_range(1, 31),
                 $urandom_range(1, 12), $urandom_range(6));
        run_tables(PHASE_ITEMS);
        set_time(0, 0, 1, 1, 0);
        run_tables(PHASE_ITEMS);

        tx_idle = 0;
        rx_idle = 0;
        repeat (2)
        begin
            set_time($urandom_range(59), $urandom_range(23), $urandom_range(1, 31),
                     $urandom_range(1, 12), $urandom_range(6));
            run_tables(PHASE_ITEMS);
        end

        if (fail_count == 0 && outstanding == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
